// ===== hdl/lkv_pkg.sv =====
// Shared constants and types for the LRU key-value cache.
package lkv_pkg;

	// Default number of cells in the row
	localparam int CAPACITY_DEF = 16;

	// Field widths
	localparam int KEY_W = 32;
	localparam int VAL_W = 31;
	localparam int CAP_W = 5;

	// Capacity register value after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Request kinds
	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_PUT = 1'b1;

	// Which cell an update command targets
	localparam logic [1:0] TGT_NONE   = 2'd0;
	localparam logic [1:0] TGT_HIT    = 2'd1;
	localparam logic [1:0] TGT_FREE   = 2'd2;
	localparam logic [1:0] TGT_VICTIM = 2'd3;

	// Update command broadcast to every cell
	typedef struct packed {
		logic       touch;   // target becomes most recent, younger entries age
		logic       fill;    // target takes a free slot, all valid entries age
		logic [1:0] tgt;     // which flagged cell is the target
		logic       wr_key;  // target stores the request key
		logic       wr_val;  // target stores the request value
	} cmd_t;

	// Per-cell flags captured in the compare cycle
	typedef struct packed {
		logic hit;         // valid and key matches
		logic first_free;  // lowest invalid cell
		logic victim;      // valid and least recent
	} flags_t;

endpackage

// ===== hdl/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: request control, row of cells, result register.
// Fully associative key-value cache with least-recently-used replacement, built as a row of
// CAPACITY cells. Each request (get or put) is taken, then every cell compares its key and
// flags itself as hit, lowest free slot or least recent entry, then one update command is
// broadcast along the row and the result is written to the output register; the update
// waits while the output register holds a result not yet taken. A new request is taken
// once the previous one has reached the output register; the output register holds a result
// while the next request is taken and compared. A get miss and every put return found = 0
// with read_value = 0. All entries are invalid after reset; no clearing pass is needed.
// capacity_in_use is written through cfg_wr_en/cfg_wr_data and is clamped to 1..CAPACITY.
module lru_key_value_cache #(
	parameter int CAPACITY = lkv_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [lkv_pkg::CAP_W-1:0]         cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              req_type,
	input  logic signed [lkv_pkg::KEY_W-1:0]  key,
	input  logic [lkv_pkg::VAL_W-1:0]         write_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              found,
	output logic [lkv_pkg::VAL_W-1:0]         read_value
);

	localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	// Request sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]                       state_q;
	logic [lkv_pkg::CAP_W-1:0]        capacity_in_use_q;
	logic [CNT_W-1:0]                 used_q;
	logic [CNT_W-1:0]                 eff_cap;
	logic                             req_type_q;
	logic signed [lkv_pkg::KEY_W-1:0] req_key_q;
	logic [lkv_pkg::VAL_W-1:0]        req_value_q;
	logic                             out_valid_q;
	logic                             found_q;
	logic [lkv_pkg::VAL_W-1:0]        read_value_q;

	logic                             accept;
	logic                             cmp_en;
	logic                             upd_go;
	logic [RANK_W-1:0]                used_m1;
	logic [RANK_W-1:0]                ref_rank;
	lkv_pkg::cmd_t                    cmd;
	logic                             res_found;

	logic                             free_c  [CAPACITY+1];
	logic                             hit_c   [CAPACITY+1];
	logic [RANK_W-1:0]                rank_c  [CAPACITY+1];
	logic [lkv_pkg::VAL_W-1:0]        value_c [CAPACITY+1];
	lkv_pkg::flags_t                  flags_c [CAPACITY];
	logic [CAPACITY-1:0]              hit_vec;
	logic [CAPACITY-1:0]              victim_vec;
	logic [CAPACITY-1:0]              free_vec;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign cmp_en     = (state_q == ST_CMP);
	assign upd_go     = (state_q == ST_UPD) && (!out_valid_q || out_ready);
	assign used_m1    = RANK_W'(used_q - CNT_W'(1));
	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign read_value = read_value_q;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_in_use_q <= lkv_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			capacity_in_use_q <= cfg_wr_data;
		end
	end

	// Clamp capacity into 1..CAPACITY
	always_comb begin
		if (capacity_in_use_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (32'(capacity_in_use_q) > 32'(CAPACITY)) begin
			eff_cap = CNT_W'(CAPACITY);
		end else begin
			eff_cap = CNT_W'(capacity_in_use_q);
		end
	end

	// Request sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_CMP;
				ST_CMP:  state_q <= ST_UPD;
				ST_UPD:  if (upd_go) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_q  <= req_type;
			req_key_q   <= key;
			req_value_q <= write_value;
		end
	end

	// Update decision from the end of the hit chain
	always_comb begin
		cmd       = '0;
		cmd.tgt   = lkv_pkg::TGT_NONE;
		ref_rank  = rank_c[CAPACITY];
		res_found = 1'b0;
		if (hit_c[CAPACITY]) begin
			cmd.touch  = 1'b1;
			cmd.tgt    = lkv_pkg::TGT_HIT;
			cmd.wr_val = (req_type_q == lkv_pkg::REQ_PUT);
			res_found  = (req_type_q == lkv_pkg::REQ_GET);
		end else if (req_type_q == lkv_pkg::REQ_PUT) begin
			cmd.wr_key = 1'b1;
			cmd.wr_val = 1'b1;
			if (used_q < eff_cap) begin
				cmd.fill = 1'b1;
				cmd.tgt  = lkv_pkg::TGT_FREE;
			end else begin
				cmd.touch = 1'b1;
				cmd.tgt   = lkv_pkg::TGT_VICTIM;
				ref_rank  = used_m1;
			end
		end
	end

	// Valid entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (upd_go && cmd.fill) begin
			used_q <= used_q + CNT_W'(1);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			found_q      <= res_found;
			read_value_q <= res_found ? value_c[CAPACITY] : '0;
		end
	end

	// Row of cells
	assign free_c[0]  = 1'b0;
	assign hit_c[0]   = 1'b0;
	assign rank_c[0]  = '0;
	assign value_c[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		lkv_cell #(
			.RANK_W (RANK_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmp_en      (cmp_en),
			.upd_en      (upd_go),
			.cmd         (cmd),
			.key         (req_key_q),
			.write_value (req_value_q),
			.ref_rank    (ref_rank),
			.used_m1     (used_m1),
			.free_in     (free_c[i]),
			.free_out    (free_c[i+1]),
			.hit_in      (hit_c[i]),
			.hit_out     (hit_c[i+1]),
			.rank_in     (rank_c[i]),
			.rank_out    (rank_c[i+1]),
			.value_in    (value_c[i]),
			.value_out   (value_c[i+1]),
			.flags       (flags_c[i])
		);
		assign hit_vec[i]    = flags_c[i].hit;
		assign victim_vec[i] = flags_c[i].victim;
		assign free_vec[i]   = flags_c[i].first_free;
	end

	// Keys are unique among valid entries
	a_hit_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("more than one cell hit");

	// Ranks of valid entries are distinct
	a_victim_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(victim_vec))
		else $error("more than one least recent cell");

	// An eviction always finds exactly one victim
	a_evict_has_victim: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && cmd.tgt == lkv_pkg::TGT_VICTIM) |-> $onehot(victim_vec))
		else $error("eviction without a single victim");

	// A fill always finds exactly one free slot
	a_fill_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && cmd.fill) |-> $onehot(free_vec))
		else $error("fill without a free slot");

	// Count never exceeds the row length
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

endmodule

// ===== hdl/lkv_cell.sv =====
// One cache entry: key, value, valid bit and recency rank, chained to its neighbors.
module lkv_cell #(
	parameter int RANK_W = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmp_en,
	input  logic                              upd_en,
	input  lkv_pkg::cmd_t                     cmd,
	input  logic signed [lkv_pkg::KEY_W-1:0]  key,
	input  logic [lkv_pkg::VAL_W-1:0]         write_value,
	input  logic [RANK_W-1:0]                 ref_rank,
	input  logic [RANK_W-1:0]                 used_m1,
	input  logic                              free_in,
	output logic                              free_out,
	input  logic                              hit_in,
	output logic                              hit_out,
	input  logic [RANK_W-1:0]                 rank_in,
	output logic [RANK_W-1:0]                 rank_out,
	input  logic [lkv_pkg::VAL_W-1:0]         value_in,
	output logic [lkv_pkg::VAL_W-1:0]         value_out,
	output lkv_pkg::flags_t                   flags
);

	logic                             valid_q;
	logic [RANK_W-1:0]                rank_q;
	logic signed [lkv_pkg::KEY_W-1:0] key_q;
	logic [lkv_pkg::VAL_W-1:0]        value_q;
	lkv_pkg::flags_t                  flags_q;
	logic                             sel;

	// Lowest-free chain: a cell is first free when it is free and no lower cell is free
	assign free_out = free_in | ~valid_q;

	// Hit chain: at most one cell hits, so an OR collects its rank and value
	assign hit_out   = hit_in | flags_q.hit;
	assign rank_out  = rank_in | (flags_q.hit ? rank_q : '0);
	assign value_out = value_in | (flags_q.hit ? value_q : '0);
	assign flags     = flags_q;

	// Target select from the broadcast command
	always_comb begin
		unique case (cmd.tgt)
			lkv_pkg::TGT_HIT:    sel = flags_q.hit;
			lkv_pkg::TGT_FREE:   sel = flags_q.first_free;
			lkv_pkg::TGT_VICTIM: sel = flags_q.victim;
			default:             sel = 1'b0;
		endcase
	end

	// Compare flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (cmp_en) begin
			flags_q.hit        <= valid_q && (key_q == key);
			flags_q.first_free <= ~valid_q & ~free_in;
			flags_q.victim     <= valid_q && (rank_q == used_m1);
		end
	end

	// Valid bit and recency rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (upd_en) begin
			if (sel) begin
				rank_q <= '0;
				if (cmd.fill) begin
					valid_q <= 1'b1;
				end
			end else if (valid_q) begin
				if (cmd.fill || (cmd.touch && rank_q < ref_rank)) begin
					rank_q <= rank_q + RANK_W'(1);
				end
			end
		end
	end

	// Stored key and value
	always_ff @(posedge clk) begin
		if (upd_en && sel) begin
			if (cmd.wr_key) begin
				key_q <= key;
			end
			if (cmd.wr_val) begin
				value_q <= write_value;
			end
		end
	end

endmodule
